@@ rtl/cbc_pkg.sv @@
// cbc_pkg: shared types, constants and state codes for the color blob centroid block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package cbc_pkg;

    localparam int NUM_COLORS   = 3;
    localparam int FRAME_WIDTH  = 40;
    localparam int COL_CENTER   = FRAME_WIDTH / 2;
    localparam int BIAS_SCALE   = 5;
    localparam int QUEUE_DEPTH  = 2;

    localparam int COUNT_W      = 11;
    localparam int SUM_W        = 16;
    localparam int PIX_W        = 8;
    localparam int COL_W        = 6;
    localparam int BIAS_W       = 8;
    localparam int QUO_W        = 7;
    localparam int REM_W        = 18;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(FRAME_WIDTH - 1);

    // color rule weights and thresholds
    localparam logic [12:0] RED_WR   = 13'd13;
    localparam logic [12:0] RED_WG   = 13'd19;
    localparam logic [12:0] RED_WB   = 13'd17;
    localparam logic [7:0]  RED_MIN  = 8'd104;
    localparam logic [12:0] GRN_WR   = 13'd16;
    localparam logic [12:0] GRN_WG   = 13'd12;
    localparam logic [12:0] GRN_WB   = 13'd14;
    localparam logic [7:0]  GRN_MIN  = 8'd92;
    localparam logic [7:0]  R_LIMIT  = 8'd160;
    localparam logic [7:0]  B_LIMIT  = 8'd200;
    localparam logic [7:0]  G_LIMIT  = 8'd200;
    localparam logic [7:0]  BLU_MIN  = 8'd96;
    localparam logic [8:0]  BLU_GAP  = 9'd20;

    localparam int C_RED   = 0;
    localparam int C_GREEN = 1;
    localparam int C_BLUE  = 2;

    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [SUM_W-1:0]   t_sum;

    typedef struct packed {
        logic [NUM_COLORS-1:0][COUNT_W-1:0] count;
        logic [NUM_COLORS-1:0][SUM_W-1:0]   sum;
    } t_snap;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_DONE
    } t_back_state;

endpackage

@@ rtl/cbc_front.sv @@
// cbc_front: pixel color classification and per-color count / column sum accumulation
// depends on cbc_pkg; pushes one accumulator snapshot per frame into the queue
`timescale 1ns / 1ps

module cbc_front
    import cbc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [PIX_W-1:0] i_red,
    input  logic [PIX_W-1:0] i_green,
    input  logic [PIX_W-1:0] i_blue,
    input  logic [COL_W-1:0] i_column,
    input  logic             i_frame_end,
    output logic             o_push,
    output t_snap            o_snap
);

    t_count r_count [NUM_COLORS];
    t_sum   r_sum   [NUM_COLORS];

    logic [NUM_COLORS-1:0] hit;
    logic [COL_W-1:0]      col_c;
    logic [12:0]           r13, g13, b13;
    t_count                upd_count [NUM_COLORS];
    t_sum                  upd_sum   [NUM_COLORS];

    always_comb begin
        r13 = {5'd0, i_red};
        g13 = {5'd0, i_green};
        b13 = {5'd0, i_blue};
        col_c = (i_column > COL_LAST) ? COL_LAST : i_column;

        hit[C_RED] = (i_red >= RED_MIN) && (r13 * RED_WR >= g13 * RED_WG)
                     && (r13 * RED_WR >= b13 * RED_WB);
        hit[C_GREEN] = (i_green >= GRN_MIN) && (i_red < R_LIMIT) && (i_blue < B_LIMIT)
                       && (g13 * GRN_WG >= r13 * GRN_WR)
                       && (g13 * GRN_WG >= b13 * GRN_WB);
        hit[C_BLUE] = (i_blue >= BLU_MIN) && (i_red < R_LIMIT) && (i_green < G_LIMIT)
                      && ({1'b0, i_blue} >= {1'b0, i_red} + BLU_GAP)
                      && ({1'b0, i_blue} > {1'b0, i_green} + BLU_GAP);
    end

    always_comb begin
        logic [SUM_W:0] sum_nx;
        for (int c = 0; c < NUM_COLORS; c++) begin
            sum_nx = {1'b0, r_sum[c]} + (SUM_W+1)'(col_c);
            if (hit[c] && (r_count[c] != {COUNT_W{1'b1}}) && !sum_nx[SUM_W]) begin
                upd_count[c] = r_count[c] + COUNT_W'(1);
                upd_sum[c]   = sum_nx[SUM_W-1:0];
            end else begin
                upd_count[c] = r_count[c];
                upd_sum[c]   = r_sum[c];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_COLORS; c++) begin
            o_snap.count[c] = upd_count[c];
            o_snap.sum[c]   = upd_sum[c];
        end
    end

    assign o_push = i_accept && i_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_COLORS; c++) begin
                r_count[c] <= '0;
                r_sum[c]   <= '0;
            end
        end else if (i_accept) begin
            for (int c = 0; c < NUM_COLORS; c++) begin
                r_count[c] <= i_frame_end ? '0 : upd_count[c];
                r_sum[c]   <= i_frame_end ? '0 : upd_sum[c];
            end
        end
    end

endmodule

@@ rtl/cbc_queue.sv @@
// cbc_queue: small register queue of frame snapshots between front and back
// depends on cbc_pkg for the snapshot type
`timescale 1ns / 1ps

module cbc_queue
    import cbc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_snap i_data,
    input  logic  i_pop,
    output t_snap o_data,
    output logic  o_full,
    output logic  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_snap          r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue pop while empty");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count above depth");
`endif

endmodule

@@ rtl/cbc_back.sv @@
// cbc_back: per-frame bias computation with a shared restoring divider and result register
// depends on cbc_pkg; takes snapshots from cbc_queue
`timescale 1ns / 1ps

module cbc_back
    import cbc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_empty,
    input  t_snap                    i_q_data,
    output logic                     o_q_pop,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [COUNT_W-1:0]       o_mass_red,
    output logic signed [BIAS_W-1:0] o_bias_red,
    output logic [COUNT_W-1:0]       o_mass_green,
    output logic signed [BIAS_W-1:0] o_bias_green,
    output logic [COUNT_W-1:0]       o_mass_blue,
    output logic signed [BIAS_W-1:0] o_bias_blue
);

    t_back_state        r_state, n_state;
    t_snap              r_snap,  n_snap;
    logic [1:0]         r_idx,   n_idx;
    logic [2:0]         r_step,  n_step;
    logic [REM_W-1:0]   r_rem,   n_rem;
    logic [QUO_W-1:0]   r_quo,   n_quo;
    logic               r_neg,   n_neg;
    t_count             r_div,   n_div;
    logic [BIAS_W-1:0]  r_bias [NUM_COLORS];
    logic [BIAS_W-1:0]  n_bias [NUM_COLORS];
    logic               r_out_valid, n_out_valid;
    t_count             r_mass_out [NUM_COLORS];
    t_count             n_mass_out [NUM_COLORS];
    logic [BIAS_W-1:0]  r_bias_out [NUM_COLORS];
    logic [BIAS_W-1:0]  n_bias_out [NUM_COLORS];

    logic                    out_load;
    logic                    sel_pulse;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_snap <= n_snap;
        r_idx  <= n_idx;
        r_step <= n_step;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_neg  <= n_neg;
        r_div  <= n_div;
        for (int c = 0; c < NUM_COLORS; c++) begin
            r_bias[c]     <= n_bias[c];
            r_mass_out[c] <= n_mass_out[c];
            r_bias_out[c] <= n_bias_out[c];
        end
    end

    always_comb begin
        t_count             cnt;
        t_sum               sum;
        logic [REM_W-1:0]   cn;
        logic signed [19:0] d5;
        logic [19:0]        mag;
        logic [REM_W-1:0]   trial;
        logic [QUO_W-1:0]   quo_nx;
        logic [BIAS_W-1:0]  qb;

        n_state     = r_state;
        n_snap      = r_snap;
        n_idx       = r_idx;
        n_step      = r_step;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_neg       = r_neg;
        n_div       = r_div;
        n_out_valid = r_out_valid;
        for (int c = 0; c < NUM_COLORS; c++) begin
            n_bias[c]     = r_bias[c];
            n_mass_out[c] = r_mass_out[c];
            n_bias_out[c] = r_bias_out[c];
        end
        o_q_pop  = 1'b0;
        out_load = 1'b0;

        cnt   = r_snap.count[r_idx];
        sum   = r_snap.sum[r_idx];
        cn    = REM_W'(cnt) * REM_W'(COL_CENTER);
        d5    = 20'(signed'({2'b00, sum} - cn)) * 20'sd5;
        mag   = d5[19] ? 20'(-d5) : 20'(d5);
        trial = REM_W'(r_div) << r_step;
        quo_nx = r_quo;
        qb     = '0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_snap  = i_q_data;
                    n_idx   = 2'd0;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_div  = cnt;
                n_neg  = d5[19];
                n_rem  = mag[REM_W-1:0];
                n_quo  = '0;
                n_step = 3'(QUO_W - 1);
                if (cnt == '0) begin
                    n_bias[r_idx] = '0;
                    if (r_idx == 2'(NUM_COLORS - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_rem >= trial) begin
                    n_rem          = r_rem - trial;
                    quo_nx[r_step] = 1'b1;
                end
                n_quo = quo_nx;
                if (r_step == 3'd0) begin
                    qb = {1'b0, quo_nx};
                    n_bias[r_idx] = r_neg ? 8'(-qb) : qb;
                    if (r_idx == 2'(NUM_COLORS - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx   = r_idx + 2'd1;
                        n_state = S_PREP;
                    end
                end else begin
                    n_step = r_step - 3'd1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    for (int c = 0; c < NUM_COLORS; c++) begin
                        n_mass_out[c] = r_snap.count[c];
                        n_bias_out[c] = r_bias[c];
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign sel_pulse = out_load;

    assign o_valid      = r_out_valid;
    assign o_mass_red   = r_mass_out[C_RED];
    assign o_bias_red   = r_bias_out[C_RED];
    assign o_mass_green = r_mass_out[C_GREEN];
    assign o_bias_green = r_bias_out[C_GREEN];
    assign o_mass_blue  = r_mass_out[C_BLUE];
    assign o_bias_blue  = r_bias_out[C_BLUE];

`ifndef SYNTH
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_div != '0))
        else $error("divide with zero divisor");
    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sel_pulse |=> r_out_valid)
        else $error("result load lost");
    a_bias_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_bias_red >= -8'sd100 && o_bias_red <= 8'sd100
                         && o_bias_green >= -8'sd100 && o_bias_green <= 8'sd100
                         && o_bias_blue >= -8'sd100 && o_bias_blue <= 8'sd100))
        else $error("bias out of range");
    a_empty_bias: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_mass_red == '0) |-> (o_bias_red == '0))
        else $error("empty color with nonzero bias");
`endif

endmodule

@@ rtl/color_blob_centroid.sv @@
// color_blob_centroid: top level of the per-frame color blob center of mass block
// depends on cbc_pkg, cbc_front, cbc_queue and cbc_back
//
//   channel   direction  handshake           payload
//   pixel     in         i_valid / o_ready   i_red i_green i_blue i_column i_frame_end
//   result    out        o_valid / i_ready   o_mass_* o_bias_* (red, green, blue)
//
// one pixel transfer per cycle while the snapshot queue has room
// with the back idle, the frame-end snapshot is queued, popped, then run through one prep step per color
// plus 7 restoring divide steps per nonempty color before o_valid is registered
// o_ready drops only while the queue holds Q_DEPTH frames not yet started
// synchronous active-low reset clears accumulators, queue and result valid
`timescale 1ns / 1ps

module color_blob_centroid
    import cbc_pkg::*;
#(
    parameter int Q_DEPTH = QUEUE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [PIX_W-1:0]         i_red,
    input  logic [PIX_W-1:0]         i_green,
    input  logic [PIX_W-1:0]         i_blue,
    input  logic [COL_W-1:0]         i_column,
    input  logic                     i_frame_end,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [COUNT_W-1:0]       o_mass_red,
    output logic signed [BIAS_W-1:0] o_bias_red,
    output logic [COUNT_W-1:0]       o_mass_green,
    output logic signed [BIAS_W-1:0] o_bias_green,
    output logic [COUNT_W-1:0]       o_mass_blue,
    output logic signed [BIAS_W-1:0] o_bias_blue
);

    logic  push, pop, q_full, q_empty;
    t_snap push_snap, pop_snap;

    assign o_ready = !q_full;

    cbc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (i_valid && !q_full),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_column    (i_column),
        .i_frame_end (i_frame_end),
        .o_push      (push),
        .o_snap      (push_snap)
    );

    cbc_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_snap),
        .i_pop   (pop),
        .o_data  (pop_snap),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    cbc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_data     (pop_snap),
        .o_q_pop      (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_mass_red   (o_mass_red),
        .o_bias_red   (o_bias_red),
        .o_mass_green (o_mass_green),
        .o_bias_green (o_bias_green),
        .o_mass_blue  (o_mass_blue),
        .o_bias_blue  (o_bias_blue)
    );

endmodule
